FILE: hdl/ewmc_pkg.sv
// Shared types, codes and constants for the encoder wheel motion controller.
// No dependencies; every other file in hdl imports this package.
package ewmc_pkg;

  // Field and register widths
  localparam int ACTION_W     = 3;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int TARGET_W     = 32;
  localparam int TOTAL_W      = 32;
  localparam int DRIVE_W      = 8;
  localparam int GAIN_W       = 24;
  localparam int ESUM_W       = 32;
  localparam int CORR_W       = 10;
  localparam int SPEED_W      = 12;

  // Parameter defaults
  localparam int COUNT_WIDTH_DEF    = 32;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Fixed control constants
  localparam logic [DRIVE_W-1:0] SLOW_STEP  = 8'd10;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX  = 8'd255;
  localparam logic [CORR_W-1:0]  CORR_LIMIT = 10'd1023;

  // Gain reset values, unsigned Q8.16
  localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd262144;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd655;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd3277;

  // Mode register codes
  localparam logic MODE_FORWARD = 1'b0;
  localparam logic MODE_ROTATE  = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LEFT_A  = 3'd0,
    ACT_LEFT_B  = 3'd1,
    ACT_RIGHT_A = 3'd2,
    ACT_RIGHT_B = 3'd3,
    ACT_TICK    = 3'd4,
    ACT_START   = 3'd5
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_TARGET    = 3'd1,
    REG_BASE      = 3'd2,
    REG_CLOCKWISE = 3'd3,
    REG_GAIN_P    = 3'd4,
    REG_GAIN_I    = 3'd5,
    REG_GAIN_D    = 3'd6
  } cfg_index_t;

  // Clamp a signed speed into the 0..255 drive range
  function automatic logic [DRIVE_W-1:0] clamp_drive(logic signed [SPEED_W-1:0] v);
    logic [DRIVE_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({4'b0000, DRIVE_MAX})) begin
      r = DRIVE_MAX;
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/ewmc_if.sv
// Valid/ready channel interfaces: input items, result items and config writes.
// Depends on ewmc_pkg for field widths.
interface ewmc_item_if import ewmc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                level_a;
  logic                level_b;
  modport source (output valid, action, level_a, level_b, input ready);
  modport sink   (input valid, action, level_a, level_b, output ready);
endinterface

interface ewmc_result_if import ewmc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DRIVE_W-1:0]        drive_a_forward;
  logic [DRIVE_W-1:0]        drive_a_reverse;
  logic [DRIVE_W-1:0]        drive_b_forward;
  logic [DRIVE_W-1:0]        drive_b_reverse;
  logic                      move_done;
  logic signed [TOTAL_W-1:0] left_total;
  logic signed [TOTAL_W-1:0] right_total;
  modport source (output valid, drive_a_forward, drive_a_reverse, drive_b_forward,
                  drive_b_reverse, move_done, left_total, right_total, input ready);
  modport sink   (input valid, drive_a_forward, drive_a_reverse, drive_b_forward,
                  drive_b_reverse, move_done, left_total, right_total, output ready);
endinterface

interface ewmc_cfg_if import ewmc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/encoder_wheel_motion_controller.sv
// Two-wheel quadrature encoder counter with forward and PID rotate move control.
// Depends on ewmc_pkg and the channel interfaces in ewmc_if.sv.
//
// The block accepts one word every clock cycle while input ready is high. Encoder edge and
// start words update the wheel state at the edge that accepts them and give no result. A
// tick word gives one result word: the accept edge captures the error terms, stage 2
// registers the three gain products, and the output register then loads the summed,
// scaled and clamped drives. Throughput stays at one word per cycle while results are
// claimed; input ready drops only while a finished result sits unclaimed in the output
// register with the pipeline behind it full. Configuration writes are always taken and
// must only happen while the block is idle.
module encoder_wheel_motion_controller
  import ewmc_pkg::*;
#(
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ewmc_cfg_if.sink      cfg,
  ewmc_item_if.sink     item,
  ewmc_result_if.source result
);

  localparam int CW   = COUNT_WIDTH;
  localparam int EW   = CW + 1;                               // error
  localparam int DW   = CW + 2;                               // error delta
  localparam int CMPW = ((CW > TARGET_W) ? CW : TARGET_W) + 1; // compares and abs
  localparam int SW   = ((EW > ESUM_W) ? EW : ESUM_W) + 1;     // integral update
  localparam int GW   = GAIN_W + 1;
  localparam int PEW  = EW + GW;
  localparam int PDW  = DW + GW;
  localparam int PSW  = ESUM_W + GW;
  localparam int PW   = ((PDW > PSW) ? PDW : PSW) + 2;
  localparam int QW   = PW - GAIN_FRAC_BITS;

  localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

  // Step a count by one, holding at the signed limits
  function automatic logic signed [CW-1:0] bump(logic signed [CW-1:0] c, logic up);
    logic signed [CW-1:0] r;
    r = c;
    if (up && c != CNT_MAX) begin
      r = c + CW'(1);
    end else if (!up && c != CNT_MIN) begin
      r = c - CW'(1);
    end
    return r;
  endfunction

  // Saturate a count to the 32-bit reported total
  function automatic logic signed [TOTAL_W-1:0] report(logic signed [CMPW-1:0] v);
    logic signed [TOTAL_W-1:0] r;
    if ((&v[CMPW-1:TOTAL_W-1]) || !(|v[CMPW-1:TOTAL_W-1])) begin
      r = v[TOTAL_W-1:0];
    end else begin
      r = v[CMPW-1] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Configuration registers
  logic                       mode;
  logic signed [TARGET_W-1:0] target;
  logic [DRIVE_W-1:0]         base;
  logic                       clockwise;
  logic [GAIN_W-1:0]          gain_p;
  logic [GAIN_W-1:0]          gain_i;
  logic [GAIN_W-1:0]          gain_d;

  // Wheel and controller state
  logic signed [CW-1:0]     left_count, left_count_next;
  logic signed [CW-1:0]     right_count, right_count_next;
  logic signed [ESUM_W-1:0] error_sum, error_sum_next;
  logic signed [EW-1:0]     last_error, last_error_next;
  logic [DRIVE_W-1:0]       held_left, held_left_next;
  logic [DRIVE_W-1:0]       held_right, held_right_next;
  logic                     finished, finished_next;

  // Stage 1: error terms of an accepted tick
  logic                      s1_valid;
  logic                      s1_rot;
  logic                      s1_done;
  logic [DRIVE_W-1:0]        s1_af, s1_bf;
  logic signed [EW-1:0]      s1_e;
  logic signed [ESUM_W-1:0]  s1_s;
  logic signed [DW-1:0]      s1_d;
  logic signed [TOTAL_W-1:0] s1_left_tot, s1_right_tot;

  // Stage 2: gain products
  logic                      s2_valid;
  logic                      s2_rot;
  logic                      s2_done;
  logic [DRIVE_W-1:0]        s2_af, s2_bf;
  logic signed [PEW-1:0]     s2_pe;
  logic signed [PSW-1:0]     s2_ps;
  logic signed [PDW-1:0]     s2_pd;
  logic signed [TOTAL_W-1:0] s2_left_tot, s2_right_tot;

  // Output register
  logic                      out_valid;
  logic [DRIVE_W-1:0]        out_af, out_ar, out_bf, out_br;
  logic                      out_done;
  logic signed [TOTAL_W-1:0] out_left_tot, out_right_tot;

  // Pipeline advance
  logic en0, en1, en2, acc;
  assign en2 = !out_valid || result.ready;
  assign en1 = !s2_valid || en2;
  assign en0 = !s1_valid || en1;
  assign acc = item.valid && en0;

  assign item.ready = en0;
  assign cfg.ready  = 1'b1;

  // Decode the accepted item against the current state
  action_t                   act;
  logic                      count_up;
  logic signed [CMPW-1:0]    left_x, right_x, target_x, left_abs, right_abs, err_full;
  logic                      reached, fin_now;
  logic signed [EW-1:0]      err;
  logic signed [DW-1:0]      err_delta;
  logic signed [SW-1:0]      sum_full;
  logic signed [ESUM_W-1:0]  sum_sat;
  logic [DRIVE_W-1:0]        slow, fwd_left, fwd_right;

  assign act      = action_t'(item.action);
  assign count_up = (act == ACT_LEFT_A || act == ACT_RIGHT_A) ?
                    (item.level_a == item.level_b) : (item.level_a != item.level_b);

  assign left_x    = CMPW'(left_count);
  assign right_x   = CMPW'(right_count);
  assign target_x  = CMPW'(target);
  assign left_abs  = left_x[CMPW-1] ? -left_x : left_x;
  assign right_abs = right_x[CMPW-1] ? -right_x : right_x;

  assign reached = (mode == MODE_ROTATE) ?
                   (left_abs >= target_x && right_abs >= target_x) :
                   (left_x >= target_x && right_x >= target_x);
  assign fin_now = finished || reached;

  assign err_full  = left_abs - right_abs;
  assign err       = EW'(err_full);
  assign err_delta = DW'(err) - DW'(last_error);
  assign sum_full  = SW'(error_sum) + SW'(err);
  assign sum_sat   = ((&sum_full[SW-1:ESUM_W-1]) || !(|sum_full[SW-1:ESUM_W-1])) ?
                     sum_full[ESUM_W-1:0] :
                     (sum_full[SW-1] ? {1'b1, {(ESUM_W-1){1'b0}}} :
                                       {1'b0, {(ESUM_W-1){1'b1}}});

  // Forward mode: slow the leading wheel
  always_comb begin
    slow      = (base >= SLOW_STEP) ? base - SLOW_STEP : '0;
    fwd_left  = held_left;
    fwd_right = held_right;
    if (left_count > right_count) begin
      fwd_left = slow;
    end else if (right_count > left_count) begin
      fwd_right = slow;
    end else begin
      fwd_left  = base;
      fwd_right = base;
    end
  end

  // Next state for the accepted item
  always_comb begin
    left_count_next  = left_count;
    right_count_next = right_count;
    error_sum_next   = error_sum;
    last_error_next  = last_error;
    held_left_next   = held_left;
    held_right_next  = held_right;
    finished_next    = finished;
    unique case (act) inside
      ACT_LEFT_A, ACT_LEFT_B: begin
        left_count_next = bump(left_count, count_up);
      end
      ACT_RIGHT_A, ACT_RIGHT_B: begin
        right_count_next = bump(right_count, count_up);
      end
      ACT_TICK: begin
        finished_next = fin_now;
        if (!fin_now) begin
          if (mode == MODE_ROTATE) begin
            error_sum_next  = sum_sat;
            last_error_next = err;
          end else begin
            held_left_next  = fwd_left;
            held_right_next = fwd_right;
          end
        end
      end
      ACT_START: begin
        left_count_next  = '0;
        right_count_next = '0;
        error_sum_next   = '0;
        last_error_next  = '0;
        finished_next    = 1'b0;
        held_left_next   = base;
        held_right_next  = base;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_FORWARD;
      target    <= '0;
      base      <= '0;
      clockwise <= 1'b0;
      gain_p    <= GAIN_P_RST;
      gain_i    <= GAIN_I_RST;
      gain_d    <= GAIN_D_RST;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        REG_MODE:      mode      <= cfg.data[0];
        REG_TARGET:    target    <= cfg.data[TARGET_W-1:0];
        REG_BASE:      base      <= cfg.data[DRIVE_W-1:0];
        REG_CLOCKWISE: clockwise <= cfg.data[0];
        REG_GAIN_P:    gain_p    <= cfg.data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i    <= cfg.data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d    <= cfg.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Commit state on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      error_sum   <= '0;
      last_error  <= '0;
      held_left   <= '0;
      held_right  <= '0;
      finished    <= 1'b0;
    end else if (acc) begin
      left_count  <= left_count_next;
      right_count <= right_count_next;
      error_sum   <= error_sum_next;
      last_error  <= last_error_next;
      held_left   <= held_left_next;
      held_right  <= held_right_next;
      finished    <= finished_next;
    end
  end

  // Stage 1: capture a tick's error terms and forward drives
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en0) begin
      s1_valid <= acc && (act == ACT_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s1_rot       <= (mode == MODE_ROTATE) && !fin_now;
      s1_done      <= fin_now;
      s1_af        <= (fin_now || mode == MODE_ROTATE) ? '0 : fwd_left;
      s1_bf        <= (fin_now || mode == MODE_ROTATE) ? '0 : fwd_right;
      s1_e         <= err;
      s1_s         <= sum_sat;
      s1_d         <= err_delta;
      s1_left_tot  <= report(left_x);
      s1_right_tot <= report(right_x);
    end
  end

  // Stage 2: the three gain products
  logic signed [PEW-1:0] prod_e;
  logic signed [PSW-1:0] prod_s;
  logic signed [PDW-1:0] prod_d;
  assign prod_e = PEW'($signed({1'b0, gain_p})) * PEW'(s1_e);
  assign prod_s = PSW'($signed({1'b0, gain_i})) * PSW'(s1_s);
  assign prod_d = PDW'($signed({1'b0, gain_d})) * PDW'(s1_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en1) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s2_rot       <= s1_rot;
      s2_done      <= s1_done;
      s2_af        <= s1_af;
      s2_bf        <= s1_bf;
      s2_pe        <= prod_e;
      s2_ps        <= prod_s;
      s2_pd        <= prod_d;
      s2_left_tot  <= s1_left_tot;
      s2_right_tot <= s1_right_tot;
    end
  end

  // Sum, scale toward zero, limit the correction and form the drives
  logic signed [PW-1:0]      pid_sum;
  logic                      pid_neg;
  logic [PW-1:0]             pid_mag;
  logic [QW-1:0]             pid_q;
  logic [CORR_W-1:0]         corr_mag;
  logic signed [SPEED_W-1:0] corr, base_s, speed_l, speed_r;
  logic [DRIVE_W-1:0]        drv_l, drv_r;
  logic [DRIVE_W-1:0]        nxt_af, nxt_ar, nxt_bf, nxt_br;

  assign pid_sum  = PW'(s2_pe) + PW'(s2_ps) + PW'(s2_pd);
  assign pid_neg  = pid_sum[PW-1];
  assign pid_mag  = pid_neg ? $unsigned(-pid_sum) : $unsigned(pid_sum);
  assign pid_q    = pid_mag[PW-1:GAIN_FRAC_BITS];
  assign corr_mag = (pid_q > QW'(CORR_LIMIT)) ? CORR_LIMIT : pid_q[CORR_W-1:0];
  assign corr     = pid_neg ? -$signed({2'b00, corr_mag}) : $signed({2'b00, corr_mag});
  assign base_s   = $signed({4'b0000, base});
  assign speed_l  = clockwise ? base_s + corr : base_s - corr;
  assign speed_r  = clockwise ? base_s - corr : base_s + corr;
  assign drv_l    = clamp_drive(speed_l);
  assign drv_r    = clamp_drive(speed_r);

  always_comb begin
    nxt_af = s2_af;
    nxt_ar = '0;
    nxt_bf = s2_bf;
    nxt_br = '0;
    if (s2_rot) begin
      if (clockwise) begin
        nxt_af = drv_l;
        nxt_bf = '0;
        nxt_br = drv_r;
      end else begin
        nxt_af = '0;
        nxt_ar = drv_l;
        nxt_bf = drv_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      out_af        <= nxt_af;
      out_ar        <= nxt_ar;
      out_bf        <= nxt_bf;
      out_br        <= nxt_br;
      out_done      <= s2_done;
      out_left_tot  <= s2_left_tot;
      out_right_tot <= s2_right_tot;
    end
  end

  assign result.valid           = out_valid;
  assign result.drive_a_forward = out_af;
  assign result.drive_a_reverse = out_ar;
  assign result.drive_b_forward = out_bf;
  assign result.drive_b_reverse = out_br;
  assign result.move_done       = out_done;
  assign result.left_total      = out_left_tot;
  assign result.right_total     = out_right_tot;

endmodule

FILE: hdl/ewmc_checker.sv
// Port-level checks for the encoder wheel motion controller, bound to the top level.
// Depends on ewmc_pkg and encoder_wheel_motion_controller.
module ewmc_checker
  import ewmc_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      item_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic [DRIVE_W-1:0]        drive_a_forward,
  input logic [DRIVE_W-1:0]        drive_a_reverse,
  input logic [DRIVE_W-1:0]        drive_b_forward,
  input logic [DRIVE_W-1:0]        drive_b_reverse,
  input logic                      move_done,
  input logic signed [TOTAL_W-1:0] left_total,
  input logic signed [TOTAL_W-1:0] right_total
);

  // A finished move stops both motors
  assert property (@(posedge clk) disable iff (rst)
    result_valid && move_done |->
      drive_a_forward == '0 && drive_a_reverse == '0 &&
      drive_b_forward == '0 && drive_b_reverse == '0)
    else $error("move_done with a nonzero drive");

  // No motor is driven both ways at once
  assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (drive_a_forward == '0 || drive_a_reverse == '0) &&
      (drive_b_forward == '0 || drive_b_reverse == '0))
    else $error("motor driven forward and reverse together");

  // Input backpressure only comes from a held result
  assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("item not ready while output is free");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(drive_a_forward) && $stable(drive_a_reverse) &&
      $stable(drive_b_forward) && $stable(drive_b_reverse) && $stable(move_done) &&
      $stable(left_total) && $stable(right_total))
    else $error("stalled result changed");

endmodule

bind encoder_wheel_motion_controller ewmc_checker u_ewmc_checker (
  .clk             (clk),
  .rst             (rst),
  .item_ready      (item.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .drive_a_forward (result.drive_a_forward),
  .drive_a_reverse (result.drive_a_reverse),
  .drive_b_forward (result.drive_b_forward),
  .drive_b_reverse (result.drive_b_reverse),
  .move_done       (result.move_done),
  .left_total      (result.left_total),
  .right_total     (result.right_total)
);
